// File: rtl/core/mwsd_pkg.sv
// Shared constants, codes and control types of the moving-window stddev margin block.
// No dependencies; every other RTL file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mwsd_pkg;

  // Field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned MarginW  = 18;
  localparam int unsigned ZW       = 12;
  localparam int unsigned FloorW   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FracW    = 8;

  // Standard deviation result width and z * sd product width
  localparam int unsigned SdW    = 16;
  localparam int unsigned ProdZW = ZW + SdW;

  localparam int unsigned DefaultWindow = 32;

  // Register reset values
  localparam logic [ZW-1:0]      ZReset     = 12'd2048;
  localparam logic [FloorW-1:0]  FloorReset = 16'd26;
  localparam logic [MarginW-1:0] MarginMax  = {MarginW{1'b1}};

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgZFactor     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFloorMargin = 2'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;    // capture sample, read oldest ring entry
    logic upd_sum;    // write ring, update sum, fill and slot
    logic upd_sumsq;  // update sum of squares
    logic mul;        // form N*Q and S*S
    logic sub;        // form N*Q - S*S, start root search
    logic root_step;  // resolve one bit of the deviation
    logic scale;      // multiply deviation by z
    logic load_out;   // load the result register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;       // window holds WINDOW samples
    logic root_last;  // current root step resolves bit zero
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/mwsd_in_if.sv
// Sample channel: valid/ready handshake with one unsigned Q8.8 sample.
// Depends on mwsd_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface mwsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [mwsd_pkg::SampleW-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mwsd_out_if.sv
// Result channel: valid/ready handshake with margin and window-full flag.
// Depends on mwsd_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface mwsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [mwsd_pkg::MarginW-1:0]  margin;
  logic                          window_full;

  modport source (output valid, output margin, output window_full, input ready);
  modport sink   (input valid, input margin, input window_full, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mwsd_ctrl.sv
// Sequencer of the moving-window stddev margin block: handshakes and step commands.
// Depends on mwsd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mwsd_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  input  wire mwsd_pkg::dp_status_t status_i,
  output mwsd_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRead  = 8'b0000_0010,
    StUpd   = 8'b0000_0100,
    StMul   = 8'b0000_1000,
    StSub   = 8'b0001_0000,
    StRoot  = 8'b0010_0000,
    StScale = 8'b0100_0000,
    StFin   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          cmd_o.load_in = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        cmd_o.upd_sum = 1'b1;
        state_d       = StUpd;
      end
      StUpd: begin
        cmd_o.upd_sumsq = 1'b1;
        state_d         = status_i.full ? StMul : StFin;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSub;
      end
      StSub: begin
        cmd_o.sub = 1'b1;
        state_d   = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = StScale;
        end
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StFin;
      end
      StFin: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == StRead)
    else $error("accepted sample did not start the update sequence");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin && out_valid_q && !out_ready_i |=> state_q == StFin && out_valid_q)
    else $error("result register overwritten while the receiver stalls");

  a_not_full_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpd && !status_i.full |=> state_q == StFin)
    else $error("partial window went through the deviation path");

  a_root_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRoot && status_i.root_last |=> state_q == StScale)
    else $error("root search did not finish after its last bit");

endmodule

`default_nettype wire

// File: rtl/core/mwsd_dp.sv
// Datapath of the moving-window stddev margin block: sample ring, running sums,
// bit-serial deviation search, scaling and result register. Depends on mwsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwsd_dp #(
  parameter int unsigned WINDOW = mwsd_pkg::DefaultWindow
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire mwsd_pkg::dp_cmd_t            cmd_i,
  output mwsd_pkg::dp_status_t              status_o,
  input  wire  [mwsd_pkg::SampleW-1:0]      sample_i,
  input  wire                               cfg_we_i,
  input  wire  [mwsd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [mwsd_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic [mwsd_pkg::MarginW-1:0]      margin_o,
  output logic                              window_full_o
);

  localparam int unsigned SampleW = mwsd_pkg::SampleW;
  localparam int unsigned SdW     = mwsd_pkg::SdW;
  localparam int unsigned SlotW   = $clog2(WINDOW);
  localparam int unsigned CntW    = $clog2(WINDOW + 1);
  localparam int unsigned SumW    = SampleW + SlotW;
  localparam int unsigned SqSampW = 2 * SampleW;
  localparam int unsigned SqW     = SqSampW + SlotW;
  localparam int unsigned ProdW   = SqW + CntW;
  localparam int unsigned SsW     = 2 * SumW;
  localparam int unsigned CmpW    = (ProdW > SsW) ? ProdW : SsW;
  localparam int unsigned AccW    = ProdW + 1;
  localparam int unsigned StepW   = $clog2(SdW);
  localparam int unsigned MW      = mwsd_pkg::ProdZW - mwsd_pkg::FracW;

  localparam logic [CntW-1:0]  FillMax = CntW'(WINDOW);
  localparam logic [SlotW-1:0] SlotMax = SlotW'(WINDOW - 1);
  // N^2 * 4^(top bit): increment term of the first search step
  localparam logic [AccW-1:0]  CInit   = AccW'(WINDOW * WINDOW) << (2 * (SdW - 1));

  // Sample ring, no reset: an entry read is used only once the window is full
  logic [SampleW-1:0] ring_mem [WINDOW];
  logic [SampleW-1:0] old_q;

  logic [SampleW-1:0]  sample_q;
  logic [SqSampW-1:0]  sample_sq_q;
  logic [SqSampW-1:0]  old_sq_q;
  logic [CntW-1:0]     fill_q;
  logic [SlotW-1:0]    slot_q;
  logic [SumW-1:0]     sum_q;
  logic [SqW-1:0]      sumsq_q;
  logic [ProdW-1:0]    nq_q;
  logic [SsW-1:0]      ss_q;
  logic [ProdW-1:0]    rem_q;
  logic [AccW-1:0]     a_q;
  logic [AccW-1:0]     c_q;
  logic [SdW-1:0]      sd_q;
  logic [StepW-1:0]    k_q;
  logic [mwsd_pkg::ProdZW-1:0] prod_q;
  logic [mwsd_pkg::ZW-1:0]     z_q;
  logic [mwsd_pkg::FloorW-1:0] floor_q;
  logic [mwsd_pkg::MarginW-1:0] margin_q;
  logic                         full_out_q;

  logic                 drop;
  logic [CmpW-1:0]      nq_ext;
  logic [CmpW-1:0]      ss_ext;
  logic [AccW-1:0]      inc;
  logic                 fits;
  logic [MW-1:0]        m_full;
  logic [mwsd_pkg::MarginW-1:0] m_sat;
  logic [mwsd_pkg::MarginW-1:0] floor_ext;
  logic [mwsd_pkg::MarginW-1:0] margin_d;

  assign drop     = (fill_q == FillMax);
  assign status_o.full      = (fill_q == FillMax);
  assign status_o.root_last = (k_q == '0);

  assign nq_ext = CmpW'(nq_q);
  assign ss_ext = CmpW'(ss_q);

  // One search step: test (N*(r + 2^k))^2 against the numerator
  assign inc  = a_q + c_q;
  assign fits = (inc <= AccW'(rem_q));

  assign m_full    = prod_q[mwsd_pkg::ProdZW-1:mwsd_pkg::FracW];
  assign m_sat     = (m_full > MW'(mwsd_pkg::MarginMax)) ? mwsd_pkg::MarginMax
                                                         : m_full[mwsd_pkg::MarginW-1:0];
  assign floor_ext = mwsd_pkg::MarginW'(floor_q);

  always_comb begin
    if (!status_o.full) begin
      margin_d = mwsd_pkg::MarginMax;
    end else if (m_sat > floor_ext) begin
      margin_d = m_sat;
    end else begin
      margin_d = floor_ext;
    end
  end

  // Ring: read the slot about to be overwritten, write it in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      old_q <= ring_mem[slot_q];
    end
    if (cmd_i.upd_sum) begin
      ring_mem[slot_q] <= sample_q;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q    <= sample_i;
      sample_sq_q <= SqSampW'(sample_i) * SqSampW'(sample_i);
    end
    if (cmd_i.upd_sum) begin
      old_sq_q <= drop ? SqSampW'(old_q) * SqSampW'(old_q) : '0;
    end
    if (cmd_i.mul) begin
      nq_q <= ProdW'(sumsq_q) * ProdW'(WINDOW);
      ss_q <= SsW'(sum_q) * SsW'(sum_q);
    end
    if (cmd_i.sub) begin
      rem_q <= (nq_ext > ss_ext) ? ProdW'(nq_ext - ss_ext) : '0;
      a_q   <= '0;
      c_q   <= CInit;
      sd_q  <= '0;
      k_q   <= StepW'(SdW - 1);
    end
    if (cmd_i.root_step) begin
      if (fits) begin
        rem_q     <= rem_q - inc[ProdW-1:0];
        sd_q[k_q] <= 1'b1;
        a_q       <= (a_q + (c_q << 1)) >> 1;
      end else begin
        a_q <= a_q >> 1;
      end
      c_q <= c_q >> 2;
      k_q <= k_q - StepW'(1);
    end
    if (cmd_i.scale) begin
      prod_q <= mwsd_pkg::ProdZW'(z_q) * mwsd_pkg::ProdZW'(sd_q);
    end
    if (cmd_i.load_out) begin
      margin_q   <= margin_d;
      full_out_q <= status_o.full;
    end
  end

  // Window state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      z_q     <= mwsd_pkg::ZReset;
      floor_q <= mwsd_pkg::FloorReset;
    end else begin
      if (cmd_i.upd_sum) begin
        sum_q  <= sum_q - (drop ? SumW'(old_q) : '0) + SumW'(sample_q);
        slot_q <= (slot_q == SlotMax) ? '0 : slot_q + SlotW'(1);
        if (!drop) begin
          fill_q <= fill_q + CntW'(1);
        end
      end
      if (cmd_i.upd_sumsq) begin
        sumsq_q <= sumsq_q - SqW'(old_sq_q) + SqW'(sample_sq_q);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mwsd_pkg::CfgZFactor:     z_q     <= cfg_data_i[mwsd_pkg::ZW-1:0];
          mwsd_pkg::CfgFloorMargin: floor_q <= cfg_data_i[mwsd_pkg::FloorW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign margin_o      = margin_q;
  assign window_full_o = full_out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count ran past the window length");

  a_partial_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !status_o.full |=> margin_q == mwsd_pkg::MarginMax && !full_out_q)
    else $error("partial window result is not the maximum margin");

  a_full_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && status_o.full |=> margin_q >= floor_ext && full_out_q)
    else $error("full window margin fell below the floor");

endmodule

`default_nettype wire

// File: rtl/core/moving_window_stddev_margin.sv
// Top level of the moving-window stddev margin block: sequencer plus datapath.
// Depends on mwsd_pkg, mwsd_in_if, mwsd_out_if, mwsd_ctrl and mwsd_dp.
//
// Usage:
//   sample_i  carries one unsigned Q8.8 sample per transaction (valid/ready).
//   result_o  carries one result per sample: margin (Q10.8) and window_full.
//   cfg_*     writes z_factor (index 0, Q4.8) or floor_margin (index 1, Q8.8)
//             at a clock edge with cfg_we_i high, drop other indexes; write only while idle.
// Timing:
//   A sample is taken only while the block is idle. Before the window fills,
//   the ring is read at the accepting edge, then follow the sum update, the
//   square-sum update and the result load. Once full, the N*Q and S*S
//   products, the subtraction, a bit-serial square-root search (one result
//   bit per cycle) and the z multiply come before the result load. The next
//   sample is taken the cycle after the result load, so a new sample waits
//   until the last one's result has been loaded.
// Reset:
//   Sums, fill count and write slot clear; registers return to z = 8.0 and
//   floor = 26. The sample ring is not cleared and needs no clearing pass.
// Back-pressure:
//   The result register holds its transaction while result_o.ready is low; a
//   new sample may be accepted meanwhile, and its result waits in the last
//   step until the register is taken.
`timescale 1ns / 1ps
`default_nettype none

module moving_window_stddev_margin #(
  parameter int unsigned WINDOW = mwsd_pkg::DefaultWindow
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  mwsd_in_if.sink                          sample_i,
  mwsd_out_if.source                       result_o,
  input  wire                              cfg_we_i,
  input  wire  [mwsd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [mwsd_pkg::CfgDataW-1:0]    cfg_data_i
);

  // Command and status between sequencer and datapath
  mwsd_pkg::dp_cmd_t    cmd;
  mwsd_pkg::dp_status_t status;

  logic in_ready;
  logic out_valid;
  logic [mwsd_pkg::MarginW-1:0] margin;
  logic window_full;

  mwsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mwsd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (sample_i.sample),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .margin_o      (margin),
    .window_full_o (window_full)
  );

  // Drive the channel ports
  assign sample_i.ready       = in_ready;
  assign result_o.valid       = out_valid;
  assign result_o.margin      = margin;
  assign result_o.window_full = window_full;

endmodule

`default_nettype wire

// File: tb/sv/tb_moving_window_stddev_margin.sv
// Self-checking testbench for moving_window_stddev_margin: random and corner samples,
// a cycle-free window predictor and an in-order scoreboard of margin results.
// Depends on mwsd_pkg, mwsd_in_if, mwsd_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_moving_window_stddev_margin;
  import mwsd_pkg::*;

  localparam int unsigned WinLen     = DefaultWindow;
  localparam int unsigned SumW       = 21;
  localparam int unsigned SumSqW     = 37;
  localparam int unsigned QuietLimit = 4000;  // far above one item's worst gap
  localparam int unsigned SettleGap  = 30;    // longer than the full deviation path
  localparam int unsigned IdlePct    = 21;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(2);  // no register at this index

  // Shape of a burst of samples
  typedef enum logic [1:0] {
    ShapeAny,    // full-range noise
    ShapeRails,  // samples at or near both ends of the range
    ShapeFlat,   // one value repeated: zero spread once the window holds only it
    ShapeBand    // narrow band around a random center
  } shape_e;

  typedef struct packed {
    logic [MarginW-1:0] margin;
    logic               full;
  } margin_rec_t;

  logic clk_i;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  mwsd_in_if  sample_ch ();
  mwsd_out_if result_ch ();

  moving_window_stddev_margin #(
    .WINDOW (WinLen)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .sample_i   (sample_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Window predictor state, shadowing the block's ring, sums and registers
  logic [SampleW-1:0] ring [WinLen];
  logic [SumW-1:0]    win_sum;
  logic [SumSqW-1:0]  win_sumsq;
  int unsigned        fill_cnt;
  int unsigned        slot;
  logic [ZW-1:0]      z_now;
  logic [FloorW-1:0]  floor_now;

  logic [SampleW-1:0] pending [$];     // samples still to be offered
  margin_rec_t        margin_due [$];  // results owed by the block, oldest first
  margin_rec_t        got;
  margin_rec_t        want;
  int unsigned        errors;
  int unsigned        quiet_cycles;
  bit                 steady;          // suppress idling on both sides

  logic [SampleW-1:0] corner_values [20] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
    16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h0100, 16'h0080, 16'h3333, 16'hCCCC,
    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF
  };

  // Floor of the square root, one result bit per pass from the top down
  function automatic logic [31:0] floor_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r[31:0];
  endfunction

  // Enter one sample into the shadow window and return the margin it yields
  function automatic margin_rec_t advance_window(logic [SampleW-1:0] s);
    margin_rec_t        rec;
    logic [SampleW-1:0] oldest;
    logic [63:0]        nq;
    logic [63:0]        ss;
    logic [63:0]        spread;
    logic [63:0]        scaled;
    if (fill_cnt >= WinLen) begin
      // drop the oldest sample from both sums
      oldest = ring[slot];
      win_sum   = win_sum - SumW'(oldest);
      win_sumsq = win_sumsq - SumSqW'(oldest) * SumSqW'(oldest);
    end else begin
      fill_cnt++;
    end
    ring[slot] = s;
    win_sum   = win_sum + SumW'(s);
    win_sumsq = win_sumsq + SumSqW'(s) * SumSqW'(s);
    slot = (slot + 1) % WinLen;

    if (fill_cnt < WinLen) begin
      rec.margin = MarginMax;
      rec.full   = 1'b0;
      return rec;
    end

    nq = 64'(WinLen) * 64'(win_sumsq);
    ss = 64'(win_sum) * 64'(win_sum);
    spread = (nq > ss) ? (nq - ss) / (64'(WinLen) * 64'(WinLen)) : 64'd0;
    scaled = (64'(z_now) * 64'(floor_root(spread))) >> FracW;
    if (scaled > 64'(MarginMax)) scaled = 64'(MarginMax);
    if (scaled <= 64'(floor_now)) scaled = 64'(floor_now);
    rec.margin = scaled[MarginW-1:0];
    rec.full   = 1'b1;
    return rec;
  endfunction

  function automatic logic [SampleW-1:0] draw_sample(shape_e shp, logic [SampleW-1:0] center);
    logic [SampleW:0] up;
    case (shp)
      ShapeRails: begin
        if ($urandom_range(0, 1) != 0) return 16'hFFFF - 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, 3));
      end
      ShapeFlat: return center;
      ShapeBand: begin
        up = 17'(center) + 17'($urandom_range(0, 255));
        return up[SampleW] ? 16'hFFFF : up[SampleW-1:0];
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue bursts of samples; most bursts follow the bias shape, the rest any shape
  task automatic queue_samples(int unsigned count, shape_e bias);
    int unsigned        left;
    int unsigned        run;
    shape_e             shp;
    logic [SampleW-1:0] center;
    left = count;
    while (left > 0) begin
      shp = ($urandom_range(0, 99) < 60) ? bias : shape_e'($urandom_range(0, 3));
      // flat runs outlast the window so the spread really reaches zero
      run = (shp == ShapeFlat) ? $urandom_range(WinLen + 2, 2 * WinLen)
                               : $urandom_range(8, 48);
      if (run > left) run = left;
      center = 16'($urandom);
      repeat (run) pending.push_back(draw_sample(shp, center));
      left -= run;
    end
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgZFactor) z_now = data[ZW-1:0];
    else if (idx == CfgFloorMargin) floor_now = data[FloorW-1:0];
  endtask

  // Hold until every sample went in and every result came out, then let the block go quiet
  task automatic settle();
    while (pending.size() != 0 || sample_ch.valid || margin_due.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sample driver: offer the next pending sample, hold it until the handshake completes
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      sample_ch.valid  <= 1'b0;
      sample_ch.sample <= '0;
    end else begin
      // predict at acceptance, with the registers as they stand now
      if (sample_ch.valid && sample_ch.ready) margin_due.push_back(advance_window(sample_ch.sample));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          sample_ch.valid  <= 1'b1;
          sample_ch.sample <= pending.pop_front();
        end else begin
          // idle: drop valid and put noise on the bus
          sample_ch.valid  <= 1'b0;
          sample_ch.sample <= 16'($urandom);
        end
      end
    end
  end

  // Result monitor: stall at random, check each transaction against the oldest expectation
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.margin = result_ch.margin;
        got.full   = result_ch.window_full;
        if (margin_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result margin=%0d full=%0b", $time, got.margin, got.full);
        end else begin
          want = margin_due.pop_front();
          if (got.margin !== want.margin) begin
            errors++;
            $display("%0t: margin mismatch expected=%0d actual=%0d",
                     $time, want.margin, got.margin);
          end
          if (got.full !== want.full) begin
            errors++;
            $display("%0t: window_full mismatch expected=%0b actual=%0b",
                     $time, want.full, got.full);
          end
        end
      end
      result_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_n || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog expired after %0d idle cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // drive every input to a known value before anything else happens
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    steady           = 1'b0;
    errors           = 0;
    quiet_cycles     = 0;

    // predictor starts from the reset state
    foreach (ring[i]) ring[i] = '0;
    win_sum   = '0;
    win_sumsq = '0;
    fill_cnt  = 0;
    slot      = 0;
    z_now     = ZReset;
    floor_now = FloorReset;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset registers: corner samples while the window fills, then mixed noise
    foreach (corner_values[i]) pending.push_back(corner_values[i]);
    queue_samples(180, ShapeAny);
    settle();

    // Largest z with spare high bits (masked off), no floor: rail-to-rail
    // samples push the product past 18 bits and saturate it
    write_reg(CfgZFactor, 16'hFFFF);
    write_reg(CfgFloorMargin, 16'h0000);
    queue_samples(200, ShapeRails);
    settle();

    // z of zero under the largest floor: the floor wins every time
    write_reg(CfgZFactor, 16'h0000);
    write_reg(CfgFloorMargin, 16'hFFFF);
    queue_samples(150, ShapeAny);
    settle();

    // Smallest nonzero z, no floor: flat runs drive the spread to zero
    write_reg(CfgZFactor, 16'h0001);
    write_reg(CfgFloorMargin, 16'h0000);
    queue_samples(150, ShapeFlat);
    settle();

    // Back to reset values, written explicitly; no idling on either side
    steady = 1'b1;
    write_reg(CfgZFactor, 16'(ZReset));
    write_reg(CfgFloorMargin, FloorReset);
    queue_samples(200, ShapeBand);
    settle();
    steady = 1'b0;

    // Random register values over mixed noise; a write to an unused index changes nothing
    write_reg(CfgZFactor, 16'($urandom));
    write_reg(CfgFloorMargin, 16'($urandom_range(0, 4095)));
    write_reg(CfgIdxSpare, 16'($urandom));
    queue_samples(200, ShapeAny);
    settle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
